// File: rtl/gsig_pkg.sv
// Shared widths, register indexes and helpers of the grid strip index generator.
package gsig_pkg;

    localparam int GRID_BITS  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int VIDX_W     = 16;

    // (row + lower) * (columns + 1) + column, full precision
    localparam int PROD_W = 2 * GRID_BITS + 3;
    localparam int CALC_W = (PROD_W > VIDX_W) ? PROD_W : VIDX_W;

    typedef logic [GRID_BITS-1:0]  t_grid;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [VIDX_W-1:0]     t_vidx;

    localparam t_cfg_idx REG_GRID_COLUMNS = t_cfg_idx'(0);
    localparam t_cfg_idx REG_GRID_ROWS    = t_cfg_idx'(1);

    // Keep the low GRID_BITS bits and treat zero as one.
    function automatic t_grid eff_size(input t_cfg_data value);
        t_grid v;
        v = value[GRID_BITS-1:0];
        return (v == '0) ? t_grid'(1) : v;
    endfunction

endpackage

// File: rtl/gsig_ifs.sv
// Valid/ready channel interfaces: restart input, index output and register writes.
interface gsig_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface gsig_out_if;
    logic                valid;
    logic                ready;
    gsig_pkg::t_vidx     strip_index;
    logic                row_last;
    logic                mesh_last;

    modport source (output valid, output strip_index, output row_last, output mesh_last,
                    input ready);
    modport sink (input valid, input strip_index, input row_last, input mesh_last,
                  output ready);
endinterface

interface gsig_cfg_if;
    logic                  valid;
    logic                  ready;
    gsig_pkg::t_cfg_idx    index;
    gsig_pkg::t_cfg_data   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/grid_strip_index_generator.sv
// Serpentine triangle-strip index generator for a grid of columns by rows cells.
//
// Each transfer on i_in yields one vertex index on o_out. Vertices are numbered
// row by row, grid_columns + 1 per row; every row is emitted as column pairs,
// upper vertex then lower, even rows left to right and odd rows right to left.
// row_last marks the lower vertex of the last pair of a row, mesh_last the last
// index of the mesh, after which the sequence wraps. restart = 1 emits the first
// index of the mesh. Register values use their low GRID_BITS bits; zero counts as
// one. Throughput is one index per cycle while o_out is not stalled: an input
// register and an output register bracket a single 9x9 multiply-add. The user must
// write registers on i_cfg only while idle; the block does not enforce this.
module grid_strip_index_generator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gsig_cfg_if.sink         i_cfg,
    gsig_in_if.sink          i_in,
    gsig_out_if.source       o_out
);

    gsig_pkg::t_cfg_data r_grid_columns;
    gsig_pkg::t_cfg_data r_grid_rows;

    // Strip position
    gsig_pkg::t_grid r_row;
    gsig_pkg::t_grid r_pos;
    logic            r_lower;

    // Input stage
    logic r_s1_valid;
    logic r_s1_restart;

    // Output stage
    logic                r_s2_valid;
    gsig_pkg::t_vidx     r_vidx;
    logic                r_row_last;
    logic                r_mesh_last;

    logic s1_adv;
    logic in_xfer;

    gsig_pkg::t_grid cols;
    gsig_pkg::t_grid rows_m1;
    gsig_pkg::t_grid cur_row;
    gsig_pkg::t_grid cur_pos;
    logic            cur_lower;
    gsig_pkg::t_grid row;
    gsig_pkg::t_grid pos;
    gsig_pkg::t_grid col;
    logic            pos_end;
    logic            row_end;
    logic [gsig_pkg::GRID_BITS:0]  vrow;
    logic [gsig_pkg::GRID_BITS:0]  stride;
    logic [gsig_pkg::CALC_W-1:0]   idx_full;

    gsig_pkg::t_grid n_row;
    gsig_pkg::t_grid n_pos;
    logic            n_lower;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= gsig_pkg::t_cfg_data'(1);
            r_grid_rows    <= gsig_pkg::t_cfg_data'(1);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                gsig_pkg::REG_GRID_COLUMNS: r_grid_columns <= i_cfg.data;
                gsig_pkg::REG_GRID_ROWS:    r_grid_rows    <= i_cfg.data;
                default:                    ;
            endcase
        end
    end

    assign s1_adv     = !r_s2_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_comb begin
        cols    = gsig_pkg::eff_size(r_grid_columns);
        rows_m1 = gsig_pkg::eff_size(r_grid_rows) - gsig_pkg::t_grid'(1);

        cur_row   = r_s1_restart ? '0 : r_row;
        cur_pos   = r_s1_restart ? '0 : r_pos;
        cur_lower = r_s1_restart ? 1'b0 : r_lower;

        // Clamp in case the registers shrank mid-mesh
        row = (cur_row < rows_m1) ? cur_row : rows_m1;
        pos = (cur_pos < cols) ? cur_pos : cols;
        col = row[0] ? (cols - pos) : pos;

        pos_end = (pos >= cols);
        row_end = (row >= rows_m1);

        vrow     = {1'b0, row} + {{gsig_pkg::GRID_BITS{1'b0}}, cur_lower};
        stride   = {1'b0, cols} + {{gsig_pkg::GRID_BITS{1'b0}}, 1'b1};
        idx_full = gsig_pkg::CALC_W'(vrow) * gsig_pkg::CALC_W'(stride)
                 + gsig_pkg::CALC_W'(col);

        n_lower = !cur_lower;
        n_row   = row;
        n_pos   = pos;
        if (cur_lower) begin
            if (pos_end) begin
                n_pos = '0;
                n_row = row_end ? '0 : row + gsig_pkg::t_grid'(1);
            end else begin
                n_pos = pos + gsig_pkg::t_grid'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_row      <= '0;
            r_pos      <= '0;
            r_lower    <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            // Advance the strip position as the item leaves the input stage
            if (r_s1_valid && s1_adv) begin
                r_row   <= n_row;
                r_pos   <= n_pos;
                r_lower <= n_lower;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_restart <= i_in.restart;
        end
        if (r_s1_valid && s1_adv) begin
            r_vidx      <= idx_full[gsig_pkg::VIDX_W-1:0];
            r_row_last  <= cur_lower && pos_end;
            r_mesh_last <= cur_lower && pos_end && row_end;
        end
    end

    assign o_out.valid       = r_s2_valid;
    assign o_out.strip_index = r_vidx;
    assign o_out.row_last    = r_row_last;
    assign o_out.mesh_last   = r_mesh_last;

endmodule

// File: rtl/gsig_checker.sv
// Port-level checks of the grid strip index generator and their bind.
module gsig_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic            i_row_last,
    input logic            i_mesh_last,
    input gsig_pkg::t_vidx i_strip_index
);

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // End of mesh is always end of a row
    a_mesh_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_mesh_last |-> i_row_last)
        else $error("mesh_last without row_last");

    // An empty output never blocks the input
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // A stalled result holds its index
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_strip_index))
        else $error("stalled result changed");

endmodule

bind grid_strip_index_generator gsig_checker u_gsig_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_row_last    (o_out.row_last),
    .i_mesh_last   (o_out.mesh_last),
    .i_strip_index (o_out.strip_index)
);
